// File: hdl/mtp_pkg.sv
// ----------------------------------------------------------------------------
// mtp_pkg: shared definitions for the MT19937 generator
// Constants of the generator and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package mtp_pkg;

  localparam int MT_WORDS = 624;
  localparam int MT_SHIFT_OFFSET = 397;

  localparam logic [31:0] MT_INIT_MULT = 32'd1812433253;
  localparam logic [31:0] MT_MATRIX    = 32'h9908B0DF;
  localparam logic [31:0] MT_TEMPER_B  = 32'h9D2C5680;
  localparam logic [31:0] MT_TEMPER_C  = 32'hEFC60000;
  localparam logic [31:0] MT_UPPER     = 32'h80000000;
  localparam logic [31:0] MT_LOWER     = 32'h7FFFFFFF;

  localparam logic [1:0] OP_SEED   = 2'd0;
  localparam logic [1:0] OP_DRAW   = 2'd1;
  localparam logic [1:0] OP_RANGED = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED_MUL,
    S_SEED_WR,
    S_TW_PRE,
    S_TW_CUR,
    S_TW_RD,
    S_TW_WR,
    S_DR_RD,
    S_DR_TEMP,
    S_MOD,
    S_ADD,
    S_DONE
  } mtp_state_t;

endpackage

`default_nettype wire

// File: hdl/mersenne_twister_prng_top.sv
// Seed: word 0 is written on accept, then S_SEED_MUL and S_SEED_WR per further word; no result word.
// Raw draw: S_DR_RD, S_DR_TEMP and S_DONE to the output register; when the index is 0 the twist
// first walks every state word (S_TW_PRE, S_TW_CUR, then S_TW_RD and S_TW_WR per word).
// Ranged draw: S_MOD for the bit-serial remainder (one bit a cycle), then S_ADD;
// none when the span wraps to zero. One item at a time; a full output register holds.
// Reset clears the sequencer, the index and the output valid; the state is unseeded.
// ----------------------------------------------------------------------------
// mersenne_twister_prng_top: MT19937 32-bit pseudo-random generator
// Seeds the state, twists it in place, tempers words and reduces them into
// a requested range with an iterative remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none

module mersenne_twister_prng_top #(
  parameter int STATE_WORDS = mtp_pkg::MT_WORDS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // seed_value, range_low, range_high
  input  wire logic [1:0]  in_tuser,   // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // value
);
  import mtp_pkg::*;

  localparam int IW = $clog2(STATE_WORDS);
  localparam logic [IW-1:0] LAST_IDX = IW'(STATE_WORDS - 1);

  mtp_state_t state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [31:0]   word_r, word_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [31:0]   lo_r, lo_nxt;
  logic [31:0]   span_r, span_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [31:0]   quo_r, quo_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [31:0]   res_r, res_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [31:0]   out_tdata_r, out_tdata_nxt;

  logic [31:0] mem [STATE_WORDS];
  logic          mem_we;
  logic [IW-1:0] mem_wa, ra1, ra2;
  logic [31:0]   mem_wd, rd1_q, rd2_q;

  logic          in_acc;
  logic [IW-1:0] k_next_wrap, k_off_wrap;
  logic [IW:0]   k_off_sum;
  logic [31:0]   tw_y, tw_w, t0, t1, t2, raw;
  logic [32:0]   rem_s;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Neighbour indexes of the twist, wrapped round the state.
  assign k_next_wrap = (k_r == LAST_IDX) ? '0 : k_r + 1'b1;
  assign k_off_sum   = {1'b0, k_r} + (IW + 1)'(MT_SHIFT_OFFSET);
  assign k_off_wrap  = (k_off_sum >= (IW + 1)'(STATE_WORDS)) ?
                       IW'(k_off_sum - (IW + 1)'(STATE_WORDS)) : k_off_sum[IW-1:0];

  assign tw_y = (word_r & MT_UPPER) | (rd1_q & MT_LOWER);
  assign tw_w = rd2_q ^ (tw_y >> 1) ^ (tw_y[0] ? MT_MATRIX : 32'h0);

  assign t0  = rd1_q ^ (rd1_q >> 11);
  assign t1  = t0 ^ ((t0 << 7) & MT_TEMPER_B);
  assign t2  = t1 ^ ((t1 << 15) & MT_TEMPER_C);
  assign raw = t2 ^ (t2 >> 18);

  // One bit of restoring remainder per cycle.
  assign rem_s = {rem_r, quo_r[31]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    rd1_q <= mem[ra1];
    rd2_q <= mem[ra2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    word_r      <= word_nxt;
    prod_r      <= prod_nxt;
    op_r        <= op_nxt;
    lo_r        <= lo_nxt;
    span_r      <= span_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    word_nxt       = word_r;
    prod_nxt       = prod_r;
    op_nxt         = op_r;
    lo_nxt         = lo_r;
    span_nxt       = span_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    res_nxt        = res_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    mem_we         = 1'b0;
    mem_wa         = k_r;
    mem_wd         = tw_w;
    ra1            = idx_r;
    ra2            = k_off_wrap;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt   = in_tuser;
          lo_nxt   = in_tdata[63:32];
          span_nxt = in_tdata[95:64] - in_tdata[63:32] + 32'd1;
          unique case (in_tuser)
            OP_SEED: begin
              mem_we    = 1'b1;
              mem_wa    = '0;
              mem_wd    = in_tdata[31:0];
              word_nxt  = in_tdata[31:0];
              k_nxt     = IW'(1);
              idx_nxt   = '0;
              state_nxt = S_SEED_MUL;
            end
            OP_DRAW, OP_RANGED: begin
              state_nxt = (idx_r == '0) ? S_TW_PRE : S_DR_RD;
            end
            // The unused code is taken and dropped.
            default: ;
          endcase
        end
      end
      S_SEED_MUL: begin
        prod_nxt  = MT_INIT_MULT * (word_r ^ (word_r >> 30));
        state_nxt = S_SEED_WR;
      end
      S_SEED_WR: begin
        mem_we   = 1'b1;
        mem_wa   = k_r;
        mem_wd   = prod_r + 32'(k_r);
        word_nxt = prod_r + 32'(k_r);
        if (k_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_SEED_MUL;
        end
      end
      S_TW_PRE: begin
        ra1       = '0;
        k_nxt     = '0;
        state_nxt = S_TW_CUR;
      end
      S_TW_CUR: begin
        word_nxt  = rd1_q;
        state_nxt = S_TW_RD;
      end
      S_TW_RD: begin
        ra1       = k_next_wrap;
        ra2       = k_off_wrap;
        state_nxt = S_TW_WR;
      end
      S_TW_WR: begin
        mem_we   = 1'b1;
        mem_wa   = k_r;
        mem_wd   = tw_w;
        word_nxt = rd1_q;
        if (k_r == LAST_IDX) begin
          state_nxt = S_DR_RD;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_TW_RD;
        end
      end
      S_DR_RD: begin
        ra1       = idx_r;
        state_nxt = S_DR_TEMP;
      end
      S_DR_TEMP: begin
        idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
        if (op_r == OP_DRAW) begin
          res_nxt   = raw;
          state_nxt = S_DONE;
        end else if (span_r == 32'd0) begin
          res_nxt   = raw + lo_r;
          state_nxt = S_DONE;
        end else begin
          rem_nxt   = '0;
          quo_nxt   = raw;
          cnt_nxt   = '0;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        rem_nxt = (rem_s >= {1'b0, span_r}) ? 32'(rem_s - {1'b0, span_r}) : rem_s[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd31) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        res_nxt   = rem_r + lo_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // The output register takes the word once the previous one has gone.
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = res_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST_IDX)
    else $error("word index beyond the state");

  a_mod_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) |-> (span_r != 32'd0))
    else $error("remainder unit running with a zero modulus");

  a_twist_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TW_WR && k_r == LAST_IDX) |=> (state_r == S_DR_RD && idx_r == '0))
    else $error("twist did not hand over to word zero");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_tvalid_r) |=> (out_tvalid_r && state_r == S_IDLE))
    else $error("finished word not moved to the output register");
`endif

endmodule

`default_nettype wire
